/* rtl/core/sobel_pkg.sv */
// Shared types and constants for the horizontal Sobel edge filter.
// No dependencies; used by sobel_lane and sobel_horizontal_edge_filter.
`default_nettype none

package sobel_pkg;

    // Frame geometry (square frame, pixels per row and rows per frame)
    localparam int IMAGE_SIZE = 256;
    localparam int COL_W      = $clog2(IMAGE_SIZE);
    localparam int ROW_W      = $clog2(IMAGE_SIZE + 2);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_SIZE - 1);
    localparam logic [ROW_W-1:0] ROW_PAD  = ROW_W'(IMAGE_SIZE);
    localparam logic [ROW_W-1:0] ROW_WRAP = ROW_W'(IMAGE_SIZE + 1);

    // Pixel layout: red in the high byte, blue in the low byte
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int NUM_CH = 3;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [PIX_W-1:0] pix_t;

    // Signed horizontal difference of one row and full gradient
    typedef logic signed [CH_W:0]   diff_t;
    typedef logic signed [CH_W+2:0] grad_t;

    localparam grad_t MAG_SAT = grad_t'(255);

    // Stage load strobes shared by the channel lanes
    typedef struct packed {
        logic ld_diff;
        logic ld_mag;
    } lane_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/sobel_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sobel_lane.sv */
// One channel lane: row differences, weighted sum, absolute value, saturation.
// Depends on sobel_pkg.
`default_nettype none

module sobel_lane
    import sobel_pkg::*;
(
    input  wire logic      clk,
    input  wire lane_ctl_t ctl,
    input  wire chan_t     lft [3],
    input  wire chan_t     rgt [3],
    output chan_t          mag
);

    diff_t diff_reg  [3];
    diff_t diff_next [3];
    grad_t g;
    grad_t g_abs;
    chan_t mag_reg;
    chan_t mag_next;

    // Right minus left per window row
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            diff_next[r] = $signed({1'b0, rgt[r]}) - $signed({1'b0, lft[r]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_diff)
        begin
            diff_reg <= diff_next;
        end
    end

    // Weighted sum 1-2-1, then min(|g|, 255)
    always_comb
    begin
        g = grad_t'(diff_reg[0]) + (grad_t'(diff_reg[1]) <<< 1) + grad_t'(diff_reg[2]);
        g_abs = g[CH_W+2] ? -g : g;
        mag_next = (g_abs > MAG_SAT) ? chan_t'(MAG_SAT) : g_abs[CH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_mag)
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

`default_nettype wire

/* rtl/core/sobel_horizontal_edge_filter.sv */
// Top level of the horizontal Sobel edge filter: stream ports, row buffer,
// 3x3 window, three channel lanes and the output register. Depends on
// sobel_pkg, sobel_ram and sobel_lane.
`default_nettype none

// Accepts one RGB pixel per clock unless stalled, in raster order,
// IMAGE_SIZE x IMAGE_SIZE pixels then IMAGE_SIZE+1 padding transactions
// whose data is ignored; the period then restarts with the next frame. Each
// output transaction carries min(|g|,255) per channel of the 3x3 horizontal
// Sobel correlation, with out-of-frame neighbors taken as zero, and is
// produced for the input transaction IMAGE_SIZE+1 after its pixel; tlast
// marks the frame's last pixel. Throughput is one transaction per clock
// unless stalled. An accepted input passes the row buffer read, row
// difference and magnitude registers. The two previous rows live in one
// 48-bit wide RAM of IMAGE_SIZE words (read on input, written as the item
// leaves stage 1), so no clearing pass is needed after reset. Output stalls
// fill pipeline bubbles first, so input keeps flowing while a result waits.
module sobel_horizontal_edge_filter
    import sobel_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic             m_tlast    // frame_end
);

    // Frame position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] ox_reg, ox_next;
    logic [COL_W-1:0] oy_reg, oy_next;

    // Stage 1: after row buffer read
    logic             s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0] s1_col_reg;
    pix_t             s1_fresh_reg;
    logic             s1_produce_reg;
    logic             s1_last_reg;
    logic [3:0]       s1_mask_reg;   // top, bottom, left, right taps usable
    logic [3:0]       mask_a;

    // Stage 2 and output
    logic s2_valid_reg, s2_valid_next;
    logic s2_last_reg;
    logic out_valid_reg, out_valid_next;
    logic out_last_reg;

    logic adv1, adv2, adv3;
    logic accept;
    logic move1;
    logic produce_a;
    logic last_a;
    pix_t fresh_a;

    logic [2*PIX_W-1:0] rows_rd;
    pix_t top_px, mid_px;

    // Window: left and center column, rows top, middle, bottom
    pix_t wc_reg [3];
    pix_t wr_reg [3];
    pix_t incoming [3];
    pix_t lft_px [3];
    pix_t rgt_px [3];

    lane_ctl_t lane_ctl;
    chan_t     lane_lft [NUM_CH][3];
    chan_t     lane_rgt [NUM_CH][3];
    chan_t     lane_mag [NUM_CH];

    // Pipeline advance, bubbles collapse
    assign adv3   = !out_valid_reg || m_tready;
    assign adv2   = !s2_valid_reg || adv3;
    assign adv1   = !s1_valid_reg || adv2;
    assign accept = s_tvalid && adv1;
    assign move1  = s1_valid_reg && adv2;

    assign s_tready = adv1;

    // Input side decode
    always_comb
    begin
        produce_a = (row_reg > ROW_W'(1)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
        last_a    = (ox_reg == COL_LAST) && (oy_reg == COL_LAST);
        fresh_a   = (row_reg < ROW_PAD) ? {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}
                                        : '0;
        mask_a    = {oy_reg != '0, oy_reg != COL_LAST, ox_reg != '0, ox_reg != COL_LAST};
    end

    // Position counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        if (accept)
        begin
            if (row_reg == ROW_WRAP)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == COL_LAST)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
            if (produce_a)
            begin
                if (ox_reg == COL_LAST)
                begin
                    ox_next = '0;
                    oy_next = (oy_reg == COL_LAST) ? '0 : oy_reg + COL_W'(1);
                end
                else
                begin
                    ox_next = ox_reg + COL_W'(1);
                end
            end
        end
    end

    // Valid flags
    always_comb
    begin
        s1_valid_next  = adv1 ? accept : s1_valid_reg;
        s2_valid_next  = adv2 ? (s1_valid_reg && s1_produce_reg) : s2_valid_reg;
        out_valid_next = adv3 ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg     <= col_reg;
            s1_fresh_reg   <= fresh_a;
            s1_produce_reg <= produce_a;
            s1_last_reg    <= last_a;
            s1_mask_reg    <= mask_a;
        end
    end

    // Two-row buffer: {upper, middle} per column
    sobel_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (IMAGE_SIZE)
    ) u_rows (
        .clk     (clk),
        .wr_en   (move1),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_px, s1_fresh_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rows_rd)
    );

    assign top_px = rows_rd[2*PIX_W-1:PIX_W];
    assign mid_px = rows_rd[PIX_W-1:0];

    // Window taps with frame border masking
    always_comb
    begin
        incoming[0] = top_px;
        incoming[1] = mid_px;
        incoming[2] = s1_fresh_reg;
        for (int r = 0; r < 3; r++)
        begin
            lft_px[r] = s1_mask_reg[1] ? wc_reg[r] : '0;
            rgt_px[r] = s1_mask_reg[0] ? incoming[r] : '0;
        end
        if (!s1_mask_reg[3])
        begin
            lft_px[0] = '0;
            rgt_px[0] = '0;
        end
        if (!s1_mask_reg[2])
        begin
            lft_px[2] = '0;
            rgt_px[2] = '0;
        end
    end

    // Window shift
    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            wc_reg <= wr_reg;
            wr_reg <= incoming;
        end
    end

    // Frame end flag follows its item
    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg && adv3)
        begin
            out_last_reg <= s2_last_reg;
        end
    end

    // Channel lanes: red, green, blue
    assign lane_ctl.ld_diff = move1;
    assign lane_ctl.ld_mag  = s2_valid_reg && adv3;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                lane_lft[c][r] = lft_px[r][PIX_W-1-c*CH_W -: CH_W];
                lane_rgt[c][r] = rgt_px[r][PIX_W-1-c*CH_W -: CH_W];
            end
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        sobel_lane u_lane (
            .clk (clk),
            .ctl (lane_ctl),
            .lft (lane_lft[c]),
            .rgt (lane_rgt[c]),
            .mag (lane_mag[c])
        );
    end

    // Output merge
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {lane_mag[2], lane_mag[1], lane_mag[0]};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* tb/tb_sobel_horizontal_edge_filter.sv */
// Self-checking testbench for sobel_horizontal_edge_filter: streams the first rows of a frame
// through the block, and checks every result against a predictor.
// Depends on sobel_pkg and the filter RTL.
module tb_sobel_horizontal_edge_filter;
    import sobel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_PIXELS = IMAGE_SIZE * IMAGE_SIZE;
    localparam int unsigned PERIOD_LAST  = FRAME_PIXELS + IMAGE_SIZE;
    localparam int unsigned PAD_ITEMS    = IMAGE_SIZE + 1;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          MAX_REPORTS  = 40;

    // Result layout mirrors m_tdata/m_tlast
    typedef struct packed {
        logic  frame_end;
        chan_t blue;
        chan_t green;
        chan_t red;
    } edge_result_t;

    typedef logic [2:0][PIX_W-1:0] tap_col_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_t;
    typedef enum {PAT_RANDOM, PAT_FLAT, PAT_STRIPE, PAT_CHECKER, PAT_DIM, PAT_RAMP}
        row_pattern_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // in_red[7:0], in_green[15:8], in_blue[23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // out_red[7:0], out_green[15:8], out_blue[23:16]
    logic        m_tlast;        // frame_end

    // Predictor state
    pix_t         upper_rows [IMAGE_SIZE];
    pix_t         middle_rows [IMAGE_SIZE];
    pix_t         window [3][3];
    int unsigned  frame_pos = 0;
    edge_result_t expected_edges [$];

    // Stimulus knobs and run statistics
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int pixels_in = 0;
    int results_checked = 0;
    int frame_ends_seen = 0;
    int quiet_cycles = 0;

    sobel_horizontal_edge_filter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < IMAGE_SIZE; i++)
        begin
            upper_rows[i] = '0;
            middle_rows[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                window[r][c] = '0;
    end

    function automatic int chan_val(input logic [PIX_W-1:0] px, input int sh);
        return int'(px[sh +: CH_W]);
    endfunction

    // min(|g|,255) of the horizontal Sobel correlation for one channel
    function automatic chan_t edge_strength(input tap_col_t lft, input tap_col_t rgt,
                                            input int sh);
        int g;
        g = (chan_val(rgt[0], sh) - chan_val(lft[0], sh))
          + 2 * (chan_val(rgt[1], sh) - chan_val(lft[1], sh))
          + (chan_val(rgt[2], sh) - chan_val(lft[2], sh));
        if (g < 0)
            g = -g;
        if (g > 255)
            g = 255;
        return chan_t'(g);
    endfunction

    // Advance the row stores and window by one transaction; queue the result it causes
    task automatic predict_item(input pix_t data);
        int unsigned  col;
        int unsigned  p;
        int unsigned  py;
        int unsigned  pxc;
        pix_t         fresh;
        pix_t         top;
        pix_t         mid;
        tap_col_t     lft;
        tap_col_t     rgt;
        bit           row_ok;
        edge_result_t res;
        col = frame_pos % IMAGE_SIZE;
        fresh = (frame_pos < FRAME_PIXELS) ? data : '0;
        top = upper_rows[col];
        mid = middle_rows[col];
        upper_rows[col] = mid;
        middle_rows[col] = fresh;
        for (int r = 0; r < 3; r++)
        begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
        end
        window[0][2] = top;
        window[1][2] = mid;
        window[2][2] = fresh;
        if (frame_pos >= PAD_ITEMS)
        begin
            p = frame_pos - PAD_ITEMS;
            py = p / IMAGE_SIZE;
            pxc = p % IMAGE_SIZE;
            // taps outside the frame read as zero
            for (int r = 0; r < 3; r++)
            begin
                row_ok = !((r == 0 && py == 0) || (r == 2 && py == IMAGE_SIZE - 1));
                lft[r] = (row_ok && pxc != 0) ? window[r][0] : '0;
                rgt[r] = (row_ok && pxc != IMAGE_SIZE - 1) ? window[r][2] : '0;
            end
            res.red = edge_strength(lft, rgt, 0);
            res.green = edge_strength(lft, rgt, CH_W);
            res.blue = edge_strength(lft, rgt, 2 * CH_W);
            res.frame_end = (frame_pos == PERIOD_LAST);
            expected_edges.push_back(res);
        end
        frame_pos = (frame_pos >= PERIOD_LAST) ? 0 : frame_pos + 1;
    endtask

    // Input monitor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_item(s_tdata);
            pixels_in++;
        end
    end

    task automatic report_field(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Result checker: every output transaction against the oldest expectation
    always @(posedge clk)
    begin : result_check
        edge_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual %h last=%b",
                             $time, m_tdata, m_tlast);
            end
            else
            begin
                want = expected_edges.pop_front();
                results_checked++;
                if (m_tdata[7:0] !== want.red)
                    report_field("out_red", want.red, m_tdata[7:0]);
                if (m_tdata[15:8] !== want.green)
                    report_field("out_green", want.green, m_tdata[15:8]);
                if (m_tdata[23:16] !== want.blue)
                    report_field("out_blue", want.blue, m_tdata[23:16]);
                if (m_tlast !== want.frame_end)
                    report_field("frame_end", want.frame_end, m_tlast);
                if (m_tlast === 1'b1)
                    frame_ends_seen++;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_sobel_horizontal_edge_filter: errors");
            $finish;
        end
    end

    task automatic set_phase(input idle_phase_t ph);
        case (ph)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 69; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default:       begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    // Send one pixel transaction, with random idle cycles ahead of it
    task automatic send_pixel(input pix_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= pix_t'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off the input until every queued result has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_edges.size() != 0)
            @(posedge clk);
    endtask

    function automatic pix_t pattern_pixel(input row_pattern_t pat, input int col,
                                           input int row, input pix_t seed);
        case (pat)
            PAT_FLAT:    return seed;
            PAT_STRIPE:  return ((col & 2) != 0) ? '1 : '0;
            PAT_CHECKER: return (((col ^ row) & 1) != 0) ? seed : '0;
            PAT_DIM:     return pix_t'($urandom) & 24'h030303;
            PAT_RAMP:    return {3{8'(col * int'(seed[2:0]))}};
            default:     return pix_t'($urandom);
        endcase
    endfunction

    task automatic send_row(input int row, input int first_col, input int last_col,
                            input row_pattern_t pat);
        pix_t seed;
        seed = pix_t'($urandom);
        for (int c = first_col; c <= last_col; c++)
            send_pixel(pattern_pixel(pat, c, row, seed));
    endtask

    function automatic row_pattern_t pick_pattern();
        return row_pattern_t'($urandom_range(int'(PAT_RAMP)));
    endfunction

    // Field extremes and single-bit patterns on the top-left corner
    task automatic test_directed_extremes();
        pix_t corner_px [20] = '{
            24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
            24'h0000FF, 24'h00FF00, 24'hFF0000,
            24'h010101, 24'h020202, 24'h040404, 24'h080808,
            24'h101010, 24'h202020, 24'h404040, 24'h808080,
            24'h7F7F7F, 24'h808080, 24'hFFFFFF, 24'hFFFFFF, 24'h000000};
        set_phase(IDLE_NONE);
        foreach (corner_px[i])
            send_pixel(corner_px[i]);
    endtask

    // Random content through the rest of the top row and the second row,
    // idle phases rotating every quarter row
    task automatic test_random_rows();
        set_phase(IDLE_SENDER);
        send_row(0, 20, IMAGE_SIZE - 1, PAT_RANDOM);
        for (int q = 0; q < 4; q++)
        begin
            set_phase(idle_phase_t'(q));
            send_row(1, q * IMAGE_SIZE / 4, (q + 1) * IMAGE_SIZE / 4 - 1, PAT_RANDOM);
        end
    endtask

    // Randomly picked patterns (random, stripes, checkers, flats, ramps, dim runs)
    // across the third row: saturation and sign of g
    task automatic test_saturation_patterns();
        wait_for_drain();
        for (int s = 0; s < 8; s++)
        begin
            set_phase(idle_phase_t'(s % 4));
            send_row(2, s * IMAGE_SIZE / 8, (s + 1) * IMAGE_SIZE / 8 - 1, pick_pattern());
        end
    endtask

    // Head of the fourth row: full-swing stripes feed the bottom taps of the third row
    task automatic test_bottom_taps();
        set_phase(IDLE_BOTH);
        send_row(3, 0, 131, PAT_STRIPE);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_rows();
        test_saturation_patterns();
        test_bottom_taps();

        // Let the pipeline empty, then watch for stray outputs
        wait_for_drain();
        set_phase(IDLE_NONE);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d pixel transactions over the first rows of a frame, top and side",
                 pixels_in);
        $display("borders included, under all four idle phases.");
        $display("Checked %0d results, %0d frame end flags, %0d field mismatches.",
                 results_checked, frame_ends_seen, mismatches);
        if (mismatches == 0)
            $display("tb_sobel_horizontal_edge_filter: clean");
        else
            $display("tb_sobel_horizontal_edge_filter: errors");
        $finish;
    end

endmodule
